// ===== rtl/size_class_free_list_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// size_class_free_list_allocator_assert.svh
// Assertion macros shared by the allocator modules.
// ---------------------------------------------------------------------------
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SCFL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication
`define SCFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ===== rtl/scfl_pkg.sv =====
// ---------------------------------------------------------------------------
// scfl_pkg
// Shared types and constants of the size class free list allocator.
// ---------------------------------------------------------------------------
package scfl_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int CLASS_IDX_W = 2;
  localparam int SIZE_W      = 20;
  localparam int SLOT_W      = 8;
  localparam int CLASS_W     = 3;
  localparam int STATUS_W    = 2;

  localparam logic [CLASS_W-1:0]  OVERSIZE_CLASS = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 2'd2;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [SIZE_W-1:0] LIMIT_RESET [NUM_CLASSES] =
    '{20'd64, 20'd256, 20'd1024, 20'd2048};

  typedef struct packed {
    logic capture;  // latch request, issue link read
    logic commit;   // update lists, register result
  } cmd_t;

endpackage

// ===== rtl/size_class_free_list_allocator.sv =====
// ---------------------------------------------------------------------------
// size_class_free_list_allocator
// Four-class segregated free list slot allocator, top level.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: a request (action, request_size, release_slot) is taken
//   at a rising edge with start high and busy low. busy is high for the one
//   cycle that follows.
//   Result channel: size_class, granted_slot and status carry a result,
//   marked by done high for exactly one cycle. The receiver cannot stall;
//   the result is registered at the end of the update state entered at
//   the accepting edge and is taken at the edge that ends the done cycle.
//   A new request is taken only once the previous one has left the update
//   state. The head pop reads the link memory at the accepting edge, and
//   the list update uses that data in the following cycle.
//   Configuration: cfg_write, cfg_index, cfg_data write a class limit at any
//   edge outside reset; change limits only while no request is in flight.
//   Reset (rst, synchronous): limits take their defaults, all lists empty,
//   no fresh slots handed out. The link memory is not cleared; its entries
//   are written before any pop reads them, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module size_class_free_list_allocator #(
  parameter int SLOTS_PER_CLASS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             action,
  input  logic [scfl_pkg::SIZE_W-1:0]      request_size,
  input  logic [scfl_pkg::SLOT_W-1:0]      release_slot,
  output logic                             done,
  output logic [scfl_pkg::CLASS_W-1:0]     size_class,
  output logic [scfl_pkg::SLOT_W-1:0]      granted_slot,
  output logic [scfl_pkg::STATUS_W-1:0]    status,
  input  logic                             cfg_write,
  input  logic [scfl_pkg::CLASS_IDX_W-1:0] cfg_index,
  input  logic [scfl_pkg::SIZE_W-1:0]      cfg_data
);

  scfl_pkg::cmd_t cmd;

  scfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  scfl_datapath #(
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (action),
    .request_size (request_size),
    .release_slot (release_slot),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .size_class   (size_class),
    .granted_slot (granted_slot),
    .status       (status)
  );

endmodule

// ===== rtl/scfl_ctrl.sv =====
// ---------------------------------------------------------------------------
// scfl_ctrl
// Request sequencer: accept, update state, result strobe.
// ---------------------------------------------------------------------------
`include "size_class_free_list_allocator_assert.svh"

module scfl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output scfl_pkg::cmd_t cmd
);

  typedef enum logic {
    IDLE,
    UPDATE
  } state_t;

  state_t state;

  assign cmd.capture = start && (state == IDLE);
  assign cmd.commit  = (state == UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (cmd.capture) begin
            state <= UPDATE;
            busy  <= 1'b1;
          end
        end
        UPDATE: begin
          state <= IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  `SCFL_ASSERT_NEXT(a_capture_busy, clk, rst, cmd.capture, busy && !done)
  `SCFL_ASSERT_NEXT(a_busy_done, clk, rst, busy, done && !busy)
  `SCFL_ASSERT_IMP(a_busy_state, clk, rst, busy, (state == UPDATE) && !cmd.capture)

endmodule

// ===== rtl/scfl_datapath.sv =====
// ---------------------------------------------------------------------------
// scfl_datapath
// Class limits, list heads, fresh counters, link memory and result registers.
// ---------------------------------------------------------------------------
`include "size_class_free_list_allocator_assert.svh"

module scfl_datapath #(
  parameter int SLOTS_PER_CLASS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  scfl_pkg::cmd_t                  cmd,
  input  logic                            action,
  input  logic [scfl_pkg::SIZE_W-1:0]     request_size,
  input  logic [scfl_pkg::SLOT_W-1:0]     release_slot,
  input  logic                            cfg_write,
  input  logic [scfl_pkg::CLASS_IDX_W-1:0] cfg_index,
  input  logic [scfl_pkg::SIZE_W-1:0]     cfg_data,
  output logic [scfl_pkg::CLASS_W-1:0]    size_class,
  output logic [scfl_pkg::SLOT_W-1:0]     granted_slot,
  output logic [scfl_pkg::STATUS_W-1:0]   status
);

  // only slots that fit the release port ever enter a list
  localparam int LINK_SLOTS = (SLOTS_PER_CLASS < 256) ? SLOTS_PER_CLASS : 256;
  localparam int AW         = $clog2(LINK_SLOTS);
  // each class owns a power-of-two block addressed by {class, slot}
  localparam int LINK_DEPTH = scfl_pkg::NUM_CLASSES * (1 << AW);
  localparam int MAW        = scfl_pkg::CLASS_IDX_W + AW;
  localparam int CW         = $clog2(SLOTS_PER_CLASS + 1);
  localparam bit ALL_FIT    = (SLOTS_PER_CLASS >= 256);

  logic [scfl_pkg::SIZE_W-1:0] limit [scfl_pkg::NUM_CLASSES];
  logic [scfl_pkg::SLOT_W-1:0] head [scfl_pkg::NUM_CLASSES];
  logic [scfl_pkg::NUM_CLASSES-1:0] nonempty;
  logic [CW-1:0] fresh [scfl_pkg::NUM_CLASSES];

  // {live, next}
  logic [scfl_pkg::SLOT_W:0] link_mem [LINK_DEPTH];
  logic [scfl_pkg::SLOT_W:0] rd_data;

  logic                          act_q;
  logic [scfl_pkg::SLOT_W-1:0]   rslot_q;
  logic [scfl_pkg::CLASS_W-1:0]  cls_q;

  logic [scfl_pkg::CLASS_W-1:0]     pick;
  logic [scfl_pkg::CLASS_IDX_W-1:0] pick_idx;
  logic [scfl_pkg::CLASS_IDX_W-1:0] c;
  logic                             slot_ok;
  logic                             do_push;
  logic [MAW-1:0]                   rd_addr;
  logic [MAW-1:0]                   wr_addr;

  always_comb begin
    pick = scfl_pkg::OVERSIZE_CLASS;
    for (int i = scfl_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
      if (request_size <= limit[i]) begin
        pick = scfl_pkg::CLASS_W'(i);
      end
    end
  end

  assign pick_idx = pick[scfl_pkg::CLASS_IDX_W-1:0];
  assign c        = cls_q[scfl_pkg::CLASS_IDX_W-1:0];
  assign rd_addr  = {pick_idx, head[pick_idx][AW-1:0]};
  assign wr_addr  = {c, rslot_q[AW-1:0]};
  assign slot_ok  = ALL_FIT || (rslot_q < scfl_pkg::SLOT_W'(SLOTS_PER_CLASS));
  assign do_push  = cmd.commit && (cls_q != scfl_pkg::OVERSIZE_CLASS) &&
                    (act_q == scfl_pkg::ACT_RELEASE) && slot_ok;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= link_mem[rd_addr];
    end
    if (do_push) begin
      link_mem[wr_addr] <= {nonempty[c], head[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q   <= action;
      rslot_q <= release_slot;
      cls_q   <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < scfl_pkg::NUM_CLASSES; i++) begin
        limit[i] <= scfl_pkg::LIMIT_RESET[i];
        head[i]  <= '0;
        fresh[i] <= '0;
      end
      nonempty     <= '0;
      size_class   <= '0;
      granted_slot <= '0;
      status       <= scfl_pkg::ST_OK;
    end else begin
      if (cfg_write) begin
        limit[cfg_index] <= cfg_data;
      end
      if (cmd.commit) begin
        size_class   <= cls_q;
        granted_slot <= '0;
        status       <= scfl_pkg::ST_OK;
        if (cls_q == scfl_pkg::OVERSIZE_CLASS) begin
          status <= scfl_pkg::ST_OVERSIZE;
        end else if (act_q == scfl_pkg::ACT_ALLOC) begin
          if (nonempty[c]) begin
            granted_slot <= head[c];
            nonempty[c]  <= rd_data[scfl_pkg::SLOT_W];
            head[c]      <= rd_data[scfl_pkg::SLOT_W] ?
                            rd_data[scfl_pkg::SLOT_W-1:0] : '0;
          end else if (fresh[c] < CW'(SLOTS_PER_CLASS)) begin
            granted_slot <= scfl_pkg::SLOT_W'(fresh[c]);
            fresh[c]     <= fresh[c] + 1'b1;
          end else begin
            status <= scfl_pkg::ST_EXHAUSTED;
          end
        end else if (slot_ok) begin
          head[c]     <= rslot_q;
          nonempty[c] <= 1'b1;
        end
      end
    end
  end

  `SCFL_ASSERT_IMP(a_ovs_status, clk, rst, size_class == scfl_pkg::OVERSIZE_CLASS,
                   status == scfl_pkg::ST_OVERSIZE)
  `SCFL_ASSERT_NEXT(a_push_nonempty, clk, rst, do_push, nonempty[$past(c)])
  `SCFL_ASSERT_IMP(a_grant_zero, clk, rst, status != scfl_pkg::ST_OK, granted_slot == '0)

endmodule

// ===== dv/scfl_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfl_result_checker
// Watches the request, result and limit write ports of the allocator, keeps
// its own copy of the class limits and free lists, and checks every result
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module scfl_result_checker #(
  parameter int SLOTS_PER_CLASS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             action,
  input  logic [scfl_pkg::SIZE_W-1:0]      request_size,
  input  logic [scfl_pkg::SLOT_W-1:0]      release_slot,
  input  logic                             done,
  input  logic [scfl_pkg::CLASS_W-1:0]     size_class,
  input  logic [scfl_pkg::SLOT_W-1:0]      granted_slot,
  input  logic [scfl_pkg::STATUS_W-1:0]    status,
  input  logic                             cfg_write,
  input  logic [scfl_pkg::CLASS_IDX_W-1:0] cfg_index,
  input  logic [scfl_pkg::SIZE_W-1:0]      cfg_data,
  output int                               mismatches,
  output int                               outstanding
);

  typedef struct packed {
    logic [scfl_pkg::CLASS_W-1:0]  cls;
    logic [scfl_pkg::SLOT_W-1:0]   slot;
    logic [scfl_pkg::STATUS_W-1:0] st;
  } alloc_result_t;

  logic [scfl_pkg::SIZE_W-1:0] limit_q    [scfl_pkg::NUM_CLASSES];
  logic [scfl_pkg::SLOT_W-1:0] head_q     [scfl_pkg::NUM_CLASSES];
  logic                        nonempty_q [scfl_pkg::NUM_CLASSES];
  int                          fresh_q    [scfl_pkg::NUM_CLASSES];
  logic [scfl_pkg::SLOT_W-1:0] link_q     [scfl_pkg::NUM_CLASSES][SLOTS_PER_CLASS];
  logic                        live_q     [scfl_pkg::NUM_CLASSES][SLOTS_PER_CLASS];
  alloc_result_t               awaited_results [$];

  function automatic alloc_result_t serve_request(logic act,
                                                  logic [scfl_pkg::SIZE_W-1:0] size,
                                                  logic [scfl_pkg::SLOT_W-1:0] rslot);
    alloc_result_t r;
    int c;
    r.cls  = scfl_pkg::OVERSIZE_CLASS;
    r.slot = '0;
    r.st   = scfl_pkg::ST_OK;
    c = scfl_pkg::NUM_CLASSES;
    // first fit in class order, limits need not ascend
    for (int i = scfl_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
      if (size <= limit_q[i]) c = i;
    end
    if (c == scfl_pkg::NUM_CLASSES) begin
      r.st = scfl_pkg::ST_OVERSIZE;
    end else begin
      r.cls = scfl_pkg::CLASS_W'(c);
      if (act == scfl_pkg::ACT_ALLOC) begin
        if (nonempty_q[c]) begin
          r.slot        = head_q[c];
          nonempty_q[c] = live_q[c][r.slot];
          head_q[c]     = live_q[c][r.slot] ? link_q[c][r.slot] : '0;
        end else if (fresh_q[c] < SLOTS_PER_CLASS) begin
          r.slot     = scfl_pkg::SLOT_W'(fresh_q[c]);
          fresh_q[c] = fresh_q[c] + 1;
        end else begin
          r.st = scfl_pkg::ST_EXHAUSTED;
        end
      end else if (rslot < SLOTS_PER_CLASS) begin
        link_q[c][rslot] = head_q[c];
        live_q[c][rslot] = nonempty_q[c];
        head_q[c]        = rslot;
        nonempty_q[c]    = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst) begin
      for (int c = 0; c < scfl_pkg::NUM_CLASSES; c++) begin
        limit_q[c]    = scfl_pkg::LIMIT_RESET[c];
        head_q[c]     = '0;
        nonempty_q[c] = 1'b0;
        fresh_q[c]    = 0;
        for (int s = 0; s < SLOTS_PER_CLASS; s++) begin
          link_q[c][s] = '0;
          live_q[c][s] = 1'b0;
        end
      end
      awaited_results.delete();
    end else begin
      if (done) begin
        got.cls  = size_class;
        got.slot = granted_slot;
        got.st   = status;
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no pending request: class %0d slot %0d status %0d",
                   $time, got.cls, got.slot, got.st);
          mismatches = mismatches + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got.cls !== want.cls) begin
            $display("%0t: size_class expected %0d actual %0d", $time, want.cls, got.cls);
            mismatches = mismatches + 1;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: granted_slot expected %0d actual %0d", $time, want.slot, got.slot);
            mismatches = mismatches + 1;
          end
          if (got.st !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            mismatches = mismatches + 1;
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(serve_request(action, request_size, release_slot));
      end
      if (cfg_write) begin
        limit_q[cfg_index] = cfg_data;
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== dv/tb_size_class_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_free_list_allocator
// Drives allocate and release requests through several class limit settings
// with random gaps; the result checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_size_class_free_list_allocator;

  localparam int SLOTS       = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [scfl_pkg::SIZE_W-1:0] MAX_SIZE = {scfl_pkg::SIZE_W{1'b1}};

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             start        = 1'b0;
  logic                             action       = scfl_pkg::ACT_ALLOC;
  logic [scfl_pkg::SIZE_W-1:0]      request_size = '0;
  logic [scfl_pkg::SLOT_W-1:0]      release_slot = '0;
  logic                             cfg_write    = 1'b0;
  logic [scfl_pkg::CLASS_IDX_W-1:0] cfg_index    = '0;
  logic [scfl_pkg::SIZE_W-1:0]      cfg_data     = '0;
  logic                             busy;
  logic                             done;
  logic [scfl_pkg::CLASS_W-1:0]     size_class;
  logic [scfl_pkg::SLOT_W-1:0]      granted_slot;
  logic [scfl_pkg::STATUS_W-1:0]    status;

  int mismatches;
  int outstanding;
  int cycle_count   = 0;
  int sent_count    = 0;
  int release_count = 0;
  int setting_count = 0;

  logic [scfl_pkg::SIZE_W-1:0] cur_limit [scfl_pkg::NUM_CLASSES];

  size_class_free_list_allocator #(
    .SLOTS_PER_CLASS(SLOTS)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .request_size(request_size), .release_slot(release_slot),
    .done(done), .size_class(size_class), .granted_slot(granted_slot), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scfl_result_checker #(
    .SLOTS_PER_CLASS(SLOTS)
  ) u_results (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .request_size(request_size), .release_slot(release_slot),
    .done(done), .size_class(size_class), .granted_slot(granted_slot), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // only_class < 0: any class, boundaries, full range
  function automatic logic [scfl_pkg::SIZE_W-1:0] random_size(int only_class);
    int mode;
    int c;
    logic [scfl_pkg::SIZE_W-1:0] v;
    mode = $urandom_range(0, 9);
    c    = $urandom_range(0, scfl_pkg::NUM_CLASSES - 1);
    if (only_class >= 0) v = scfl_pkg::SIZE_W'($urandom_range(0, cur_limit[only_class]));
    else if (mode < 6) v = scfl_pkg::SIZE_W'($urandom_range(0, cur_limit[c]));
    else if (mode < 8) v = scfl_pkg::SIZE_W'(cur_limit[c] + $urandom_range(0, 2) - 1);
    else if (mode == 8) v = scfl_pkg::SIZE_W'($urandom);
    else v = $urandom_range(0, 1) ? MAX_SIZE : '0;
    return v;
  endfunction

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(logic act, logic [scfl_pkg::SIZE_W-1:0] size,
                       logic [scfl_pkg::SLOT_W-1:0] slot, bit tight);
    start        <= 1'b1;
    action       <= act;
    request_size <= size;
    release_slot <= slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count = sent_count + 1;
    if (act == scfl_pkg::ACT_RELEASE) release_count = release_count + 1;
    pause(tight ? 0 : gap_cycles());
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(logic [scfl_pkg::SIZE_W-1:0] l0, logic [scfl_pkg::SIZE_W-1:0] l1,
                            logic [scfl_pkg::SIZE_W-1:0] l2, logic [scfl_pkg::SIZE_W-1:0] l3);
    logic [scfl_pkg::SIZE_W-1:0] vals [scfl_pkg::NUM_CLASSES];
    vals[0] = l0;
    vals[1] = l1;
    vals[2] = l2;
    vals[3] = l3;
    drain();
    for (int i = 0; i < scfl_pkg::NUM_CLASSES; i++) begin
      cfg_write    <= 1'b1;
      cfg_index    <= scfl_pkg::CLASS_IDX_W'(i);
      cfg_data     <= vals[i];
      cur_limit[i] = vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    setting_count = setting_count + 1;
  endtask

  task automatic random_run(int n, int release_pct, int only_class);
    bit tight;
    logic act;
    tight = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) tight = ($urandom_range(0, 3) == 0);
      act = ($urandom_range(0, 99) < release_pct) ? scfl_pkg::ACT_RELEASE
                                                   : scfl_pkg::ACT_ALLOC;
      issue(act, random_size(only_class), scfl_pkg::SLOT_W'($urandom_range(0, SLOTS - 1)),
            tight);
    end
  endtask

  initial begin
    for (int i = 0; i < scfl_pkg::NUM_CLASSES; i++) cur_limit[i] = scfl_pkg::LIMIT_RESET[i];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // class edges at reset limits
    issue(scfl_pkg::ACT_ALLOC, 0, 8'hFF, 0);
    issue(scfl_pkg::ACT_ALLOC, 64, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 65, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 256, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 257, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 1024, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 1025, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 2048, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 2049, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, MAX_SIZE, 0, 0);
    issue(scfl_pkg::ACT_RELEASE, MAX_SIZE, 8'hFF, 0);
    // LIFO reuse then fresh slot
    issue(scfl_pkg::ACT_RELEASE, 10, 1, 0);
    issue(scfl_pkg::ACT_RELEASE, 10, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 10, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 10, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 10, 0, 0);
    // never-used slot released twice, then granted to all three allocations
    issue(scfl_pkg::ACT_RELEASE, 300, 8'hFF, 0);
    issue(scfl_pkg::ACT_RELEASE, 300, 8'hFF, 0);
    issue(scfl_pkg::ACT_ALLOC, 300, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 300, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 300, 0, 0);
    issue(scfl_pkg::ACT_RELEASE, 2000, 8'hAA, 0);
    issue(scfl_pkg::ACT_RELEASE, 2000, 8'h55, 0);
    issue(scfl_pkg::ACT_ALLOC, 1500, 0, 0);
    issue(scfl_pkg::ACT_ALLOC, 1500, 0, 0);

    random_run(150, 40, -1);
    set_limits(1, 2, 3, MAX_SIZE);
    random_run(330, 0, 0);           // drive class 0 into exhaustion
    random_run(120, 45, -1);
    set_limits(MAX_SIZE, 3, 16, MAX_SIZE);
    random_run(150, 50, -1);
    set_limits(5000, 100, 200000, 10);
    random_run(200, 40, -1);
    set_limits(1, 1, 1, 1);
    random_run(100, 40, -1);
    repeat (2) begin
      set_limits(scfl_pkg::SIZE_W'($urandom_range(1, MAX_SIZE)),
                 scfl_pkg::SIZE_W'($urandom_range(1, MAX_SIZE)),
                 scfl_pkg::SIZE_W'($urandom_range(1, MAX_SIZE)),
                 scfl_pkg::SIZE_W'($urandom_range(1, MAX_SIZE)));
      random_run(90, 40, -1);
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Drove %0d requests (%0d releases) over %0d limit settings plus reset limits,",
             sent_count, release_count, setting_count);
    $display("covering class edges, oversize, LIFO reuse, double release and exhaustion.");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
